/* rtl/core/hbp_pkg.sv */
package hbp_pkg;

	localparam int CodeWidth   = 32;
	localparam int LenWidth    = 6;
	localparam int SymWidth    = 7;
	localparam int SymbolCount = 128;
	localparam int MaxCodeLen  = 32;
	localparam int CountWidth  = 16;
	localparam int AccWidth    = CodeWidth + 8;
	localparam int QueueDepth  = 4;

	localparam logic [CountWidth-1:0] CapMin = 16'd8;
	localparam logic [CountWidth-1:0] CapMax = 16'd65504;

	localparam logic [1:0] OpLoad   = 2'd0;
	localparam logic [1:0] OpEncode = 2'd1;
	localparam logic [1:0] OpFlush  = 2'd2;

	localparam logic KindData = 1'b0;
	localparam logic KindEnd  = 1'b1;

	typedef struct packed {
		logic [1:0]          op;
		logic [SymWidth-1:0] symbol;
		logic [31:0]         code_bits;
		logic [5:0]          code_length;
	} cmd_t;

	typedef struct packed {
		logic                  kind;
		logic [7:0]            data_byte;
		logic [CountWidth-1:0] block_symbol_count;
		logic [CountWidth-1:0] block_bit_count;
		logic                  last;
	} result_t;

	// table entry: code left-aligned, length
	typedef struct packed {
		logic [CodeWidth-1:0] code;
		logic [LenWidth-1:0]  len;
	} entry_t;

	// work passed from front to back
	typedef struct packed {
		logic   is_flush;
		entry_t entry;
	} work_t;

endpackage

/* rtl/core/hbp_queue.sv */
module hbp_queue (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      wr_en,
	input  hbp_pkg::work_t                            wr_data,
	input  logic                                      rd_en,
	output hbp_pkg::work_t                            rd_data,
	output logic [$clog2(hbp_pkg::QueueDepth+1)-1:0]  count
);

	localparam int PtrWidth = $clog2(hbp_pkg::QueueDepth);

	hbp_pkg::work_t slot_q [hbp_pkg::QueueDepth];
	logic [PtrWidth-1:0] wr_ptr_q;
	logic [PtrWidth-1:0] rd_ptr_q;
	logic [$clog2(hbp_pkg::QueueDepth+1)-1:0] count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_data = slot_q[rd_ptr_q];
	assign count   = count_q;

endmodule

/* rtl/core/hbp_front.sv */
module hbp_front (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      push,
	input  hbp_pkg::cmd_t                             cmd,
	output logic                                      full,
	input  logic [$clog2(hbp_pkg::QueueDepth+1)-1:0]  q_count,
	output logic                                      q_wr_en,
	output hbp_pkg::work_t                            q_wr_data
);

	hbp_pkg::entry_t table_q [hbp_pkg::SymbolCount];
	hbp_pkg::entry_t rd_q;
	hbp_pkg::entry_t load_entry;
	logic            accept;
	logic [hbp_pkg::LenWidth-1:0] len_sat;
	logic            valid_s1;
	logic            flush_s1;

	assign accept = push && !full;

	// in-flight item in s1 counts against the queue space
	assign full = ({1'b0, q_count} + {{$clog2(hbp_pkg::QueueDepth+1){1'b0}}, valid_s1})
		>= ($clog2(hbp_pkg::QueueDepth+1)+1)'(hbp_pkg::QueueDepth);

	always_comb begin
		len_sat = (cmd.code_length > hbp_pkg::LenWidth'(hbp_pkg::MaxCodeLen))
			? hbp_pkg::LenWidth'(hbp_pkg::MaxCodeLen) : cmd.code_length;
		// left-align; drops stray bits above the length, zero length gives zero
		load_entry.code = cmd.code_bits << (hbp_pkg::LenWidth'(hbp_pkg::CodeWidth) - len_sat);
		load_entry.len  = len_sat;
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.op == hbp_pkg::OpLoad) begin
			table_q[cmd.symbol] <= load_entry;
		end
		rd_q <= table_q[cmd.symbol];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flush_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && (cmd.op == hbp_pkg::OpEncode || cmd.op == hbp_pkg::OpFlush);
			flush_s1 <= cmd.op == hbp_pkg::OpFlush;
		end
	end

	assign q_wr_en            = valid_s1;
	assign q_wr_data.is_flush = flush_s1;
	assign q_wr_data.entry    = rd_q;

endmodule

/* rtl/core/hbp_back.sv */
module hbp_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [hbp_pkg::CountWidth-1:0]     capacity,
	input  logic                               q_valid,
	input  hbp_pkg::work_t                     q_data,
	output logic                               q_rd_en,
	output logic                               empty,
	input  logic                               pop,
	output hbp_pkg::result_t                   result
);

	localparam int AW = hbp_pkg::AccWidth;
	localparam int CW = hbp_pkg::CountWidth;

	logic [AW-1:0]  acc_q;
	logic [5:0]     nb_q;
	logic [CW-1:0]  bits_q;
	logic [CW-1:0]  syms_q;
	logic           pad_pend_q;
	logic           end_pend_q;
	logic [7:0]     pad_byte_q;
	logic [CW-1:0]  end_syms_q;
	logic [CW-1:0]  end_bits_q;
	logic           out_valid_q;
	hbp_pkg::result_t out_q;

	logic           busy;
	logic           slot_free;
	logic           take;
	logic           emit;
	logic [CW-1:0]  cap_eff;
	logic           has_syms;
	logic           close;
	logic [2:0]     fill;
	logic [7:0]     base;
	logic [AW-1:0]  acc_new;
	logic [5:0]     nb_new;
	logic [CW:0]    need;

	assign busy      = pad_pend_q || end_pend_q || (nb_q >= 6'd8);
	assign slot_free = !out_valid_q || pop;
	assign take      = !busy && q_valid;
	assign emit      = busy && slot_free;
	assign q_rd_en   = take;

	always_comb begin
		if (capacity < hbp_pkg::CapMin) begin
			cap_eff = hbp_pkg::CapMin;
		end else if (capacity > hbp_pkg::CapMax) begin
			cap_eff = hbp_pkg::CapMax;
		end else begin
			cap_eff = capacity;
		end
		has_syms = syms_q != '0;
		need     = {1'b0, bits_q} + (CW+1)'(q_data.entry.len);
		close    = q_data.is_flush ? has_syms : (has_syms && need > {1'b0, cap_eff});
		fill     = close ? 3'd0 : bits_q[2:0];
		base     = close ? 8'd0 : acc_q[AW-1 -: 8];
		acc_new  = {base, {(AW-8){1'b0}}} | ({q_data.entry.code, 8'd0} >> fill);
		nb_new   = {3'd0, fill} + q_data.entry.len;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pad_byte_q <= acc_q[AW-1 -: 8];
			end_syms_q <= syms_q;
			end_bits_q <= bits_q;
		end
		if (emit) begin
			priority if (pad_pend_q) begin
				out_q.kind               <= hbp_pkg::KindData;
				out_q.data_byte          <= pad_byte_q;
				out_q.block_symbol_count <= '0;
				out_q.block_bit_count    <= '0;
				out_q.last               <= 1'b0;
			end else if (end_pend_q) begin
				out_q.kind               <= hbp_pkg::KindEnd;
				out_q.data_byte          <= '0;
				out_q.block_symbol_count <= end_syms_q;
				out_q.block_bit_count    <= end_bits_q;
				out_q.last               <= nb_q < 6'd8;
			end else begin
				out_q.kind               <= hbp_pkg::KindData;
				out_q.data_byte          <= acc_q[AW-1 -: 8];
				out_q.block_symbol_count <= '0;
				out_q.block_bit_count    <= '0;
				out_q.last               <= nb_q < 6'd16;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			nb_q        <= '0;
			bits_q      <= '0;
			syms_q      <= '0;
			pad_pend_q  <= 1'b0;
			end_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end

			if (take) begin
				pad_pend_q <= close && (bits_q[2:0] != 3'd0);
				end_pend_q <= close;
				if (q_data.is_flush) begin
					if (close) begin
						acc_q  <= '0;
						bits_q <= '0;
						syms_q <= '0;
					end
					nb_q <= '0;
				end else begin
					acc_q  <= acc_new;
					nb_q   <= nb_new;
					bits_q <= close ? CW'(q_data.entry.len) : need[CW-1:0];
					if (close) begin
						syms_q <= CW'(1);
					end else if (syms_q != {CW{1'b1}}) begin
						syms_q <= syms_q + 1'b1;
					end
				end
			end else if (emit) begin
				priority if (pad_pend_q) begin
					pad_pend_q <= 1'b0;
				end else if (end_pend_q) begin
					end_pend_q <= 1'b0;
				end else begin
					acc_q <= {acc_q[AW-9:0], 8'd0};
					nb_q  <= nb_q - 6'd8;
				end
			end
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

/* rtl/core/huffman_block_bit_packer.sv */
// channel   direction  handshake              payload
// cmd       in         push / full            hbp_pkg::cmd_t
// result    out        pop / empty            hbp_pkg::result_t
// cfg       in         cfg_valid / cfg_ready  block capacity in bits (16 bit)
//
// A registered table lookup in the front, then a four-entry queue. An item passes the front's
// lookup register, the queue, the back's accumulator and the output register in turn. The back
// takes one item a cycle with nothing pending, then emits one result a cycle while the output
// register is free or popped. Reset clears block counters, the queue and the output valid flag;
// the code table is not cleared and must be loaded before use. full rises when the queue plus
// the item in flight fill it; pop low holds the output register and stalls the back only.
module huffman_block_bit_packer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  hbp_pkg::cmd_t                      cmd,
	output logic                               empty,
	input  logic                               pop,
	output hbp_pkg::result_t                   result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [hbp_pkg::CountWidth-1:0]     cfg_data
);

	logic [hbp_pkg::CountWidth-1:0]               cap_q;
	logic [$clog2(hbp_pkg::QueueDepth+1)-1:0]    q_count;
	logic                                         q_wr_en;
	hbp_pkg::work_t                               q_wr_data;
	logic                                         q_rd_en;
	hbp_pkg::work_t                               q_rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= hbp_pkg::CapMax;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	hbp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.cmd       (cmd),
		.full      (full),
		.q_count   (q_count),
		.q_wr_en   (q_wr_en),
		.q_wr_data (q_wr_data)
	);

	hbp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr_en),
		.wr_data (q_wr_data),
		.rd_en   (q_rd_en),
		.rd_data (q_rd_data),
		.count   (q_count)
	);

	hbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.capacity (cap_q),
		.q_valid  (q_count != '0),
		.q_data   (q_rd_data),
		.q_rd_en  (q_rd_en),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule
